>>> hw/rtl/rconv_pkg.sv
// Package for the radix converter: shared types, codes and reset constants.
// Used by rconv_ctrl, rconv_dp and radix_converter_top; depends on nothing.
`default_nettype none

package rconv_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] NEG_MARK        = 8'hFF;
    localparam logic [7:0] SOURCE_BASE_RST = 8'd10;
    localparam logic [7:0] TARGET_BASE_RST = 8'd2;
    localparam logic [7:0] MIN_TARGET_BASE = 8'd2;

    typedef enum logic
    {
        REG_SOURCE_BASE = 1'b0,
        REG_TARGET_BASE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DNEXT,
        S_SIGN,
        S_POP,
        S_EMIT,
        S_ERR
    } state_t;

    typedef struct packed
    {
        logic accept;     // input beat taken this cycle
        logic load;       // latch final value, clear per-number state
        logic div_init;   // start a new division
        logic div_step;   // one quotient bit
        logic pop;        // read top of digit stack
        logic out_sign;   // load negative mark into output stage
        logic out_digit;  // load popped digit into output stage
        logic out_err;    // load error beat into output stage
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic sel_err;     // final value carries an error
        logic bit_last;    // division on its final bit
        logic quot_zero;   // quotient is zero
        logic stack_full;  // digit stack full
        logic neg_emit;    // negative mark must be sent
        logic stack_empty; // no digits left
        logic out_free;    // output stage can take a beat
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rconv_ctrl.sv
// Controller state machine for the radix converter.
// Depends on rconv_pkg; drives rconv_dp through command/status structs.
`default_nettype none

module rconv_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tlast,
    output logic                      s_tready,
    input  wire rconv_pkg::dp_stat_t  stat,
    output rconv_pkg::ctrl_cmd_t      cmd
);

    rconv_pkg::state_t state_reg;
    rconv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rconv_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rconv_pkg::S_IDLE:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = rconv_pkg::S_LOAD;
                end
            end
            rconv_pkg::S_LOAD:
            begin
                state_next = stat.sel_err ? rconv_pkg::S_ERR : rconv_pkg::S_DIV;
            end
            rconv_pkg::S_DIV:
            begin
                if (stat.bit_last)
                begin
                    state_next = rconv_pkg::S_DNEXT;
                end
            end
            rconv_pkg::S_DNEXT:
            begin
                state_next = (stat.quot_zero || stat.stack_full) ?
                             rconv_pkg::S_SIGN : rconv_pkg::S_DIV;
            end
            rconv_pkg::S_SIGN:
            begin
                if (!stat.neg_emit || stat.out_free)
                begin
                    state_next = rconv_pkg::S_POP;
                end
            end
            rconv_pkg::S_POP:
            begin
                state_next = rconv_pkg::S_EMIT;
            end
            rconv_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.stack_empty ? rconv_pkg::S_IDLE : rconv_pkg::S_POP;
                end
            end
            rconv_pkg::S_ERR:
            begin
                if (stat.out_free)
                begin
                    state_next = rconv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rconv_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            rconv_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            rconv_pkg::S_LOAD:
            begin
                cmd.load     = 1'b1;
                cmd.div_init = 1'b1;
            end
            rconv_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            rconv_pkg::S_DNEXT:
            begin
                cmd.div_init = !(stat.quot_zero || stat.stack_full);
            end
            rconv_pkg::S_SIGN:
            begin
                cmd.out_sign = stat.neg_emit && stat.out_free;
            end
            rconv_pkg::S_POP:
            begin
                cmd.pop = 1'b1;
            end
            rconv_pkg::S_EMIT:
            begin
                cmd.out_digit = stat.out_free;
            end
            rconv_pkg::S_ERR:
            begin
                cmd.out_err = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/rconv_dp.sv
// Datapath for the radix converter: config registers, accumulator,
// bit-serial divider, digit stack and output stage. Depends on rconv_pkg.
`default_nettype none

module rconv_dp
#(
    parameter int VALUE_BITS  = rconv_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = rconv_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire rconv_pkg::cfg_reg_t  cfg_addr,
    input  wire logic [7:0]           cfg_data,
    input  wire logic [7:0]           digit_in,
    input  wire rconv_pkg::ctrl_cmd_t cmd,
    output rconv_pkg::dp_stat_t       stat,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast,
    output logic [1:0]                m_tuser
);

    localparam int MAG_BITS = VALUE_BITS - 1;
    localparam int PW       = MAG_BITS + 9;
    localparam int BW       = $clog2(MAG_BITS);
    localparam int AW       = $clog2(STACK_DEPTH);
    localparam int CW       = $clog2(STACK_DEPTH + 1);

    // configuration
    logic [7:0] src_base_reg;
    logic [7:0] tgt_base_reg;
    logic [7:0] tb_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_base_reg <= rconv_pkg::SOURCE_BASE_RST;
            tgt_base_reg <= rconv_pkg::TARGET_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rconv_pkg::REG_SOURCE_BASE: src_base_reg <= cfg_data;
                rconv_pkg::REG_TARGET_BASE: tgt_base_reg <= cfg_data;
                default:                    src_base_reg <= src_base_reg;
            endcase
        end
    end

    assign tb_eff = (tgt_base_reg < rconv_pkg::MIN_TARGET_BASE) ?
                    rconv_pkg::MIN_TARGET_BASE : tgt_base_reg;

    // per-number accumulation
    logic [MAG_BITS-1:0]   acc_reg,  acc_next;
    logic                  neg_reg,  neg_next;
    logic [VALUE_BITS-1:0] cnt_reg,  cnt_next;
    rconv_pkg::status_t    err_reg,  err_next;
    logic [PW-1:0]         prod;
    logic                  unary;

    assign unary = (src_base_reg == 8'd1);
    assign prod  = PW'(acc_reg) * PW'(src_base_reg) + PW'(digit_in);

    always_comb
    begin
        acc_next = acc_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (cmd.load)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            cnt_next = '0;
            err_next = rconv_pkg::ST_OK;
        end
        else if (cmd.accept)
        begin
            // count saturates one above the magnitude limit
            if (!cnt_reg[VALUE_BITS-1])
            begin
                cnt_next = cnt_reg + VALUE_BITS'(1);
            end
            if (!unary)
            begin
                if (digit_in == rconv_pkg::NEG_MARK)
                begin
                    acc_next = '0;
                    neg_next = 1'b1;
                    err_next = rconv_pkg::ST_OK;
                end
                else if (err_reg == rconv_pkg::ST_OK)
                begin
                    if (digit_in >= src_base_reg)
                    begin
                        err_next = rconv_pkg::ST_BAD_DIGIT;
                    end
                    else if (|prod[PW-1:MAG_BITS])
                    begin
                        err_next = rconv_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = prod[MAG_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            neg_reg <= 1'b0;
            cnt_reg <= '0;
            err_reg <= rconv_pkg::ST_OK;
        end
        else
        begin
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    // final value select
    logic [MAG_BITS-1:0] val_sel;
    logic                neg_sel;
    rconv_pkg::status_t  st_sel;

    always_comb
    begin
        if (unary)
        begin
            val_sel = cnt_reg[MAG_BITS-1:0];
            neg_sel = 1'b0;
            st_sel  = cnt_reg[VALUE_BITS-1] ? rconv_pkg::ST_OVERFLOW : rconv_pkg::ST_OK;
        end
        else
        begin
            val_sel = acc_reg;
            neg_sel = neg_reg;
            st_sel  = err_reg;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [MAG_BITS-1:0] q_reg,    q_next;
    logic [7:0]          rem_reg,  rem_next;
    logic [BW-1:0]       bit_reg,  bit_next;
    logic                nege_reg, nege_next;
    logic [8:0]          trial;
    logic                ge;
    logic [7:0]          rem_step;
    logic                push;

    assign trial    = {rem_reg, q_reg[MAG_BITS-1]};
    assign ge       = (trial >= {1'b0, tb_eff});
    assign rem_step = ge ? 8'(trial - {1'b0, tb_eff}) : trial[7:0];
    assign push     = cmd.div_step && (bit_reg == '0);

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        nege_next = nege_reg;
        if (cmd.load)
        begin
            q_next    = val_sel;
            nege_next = neg_sel && (val_sel != '0);
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            bit_next = BW'(MAG_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_step;
            q_next   = {q_reg[MAG_BITS-2:0], ge};
            bit_next = bit_reg - BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        nege_reg <= nege_next;
    end

    // digit stack
    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] sp_dec;

    assign sp_dec = sp_reg - CW'(1);

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.load)
        begin
            sp_next = '0;
        end
        else if (push)
        begin
            sp_next = sp_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg[AW-1:0]] <= rem_step;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= stack_mem[sp_dec[AW-1:0]];
        end
    end

    // error status held from the load cycle
    logic [1:0] st_sel_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_sel_q_reg <= st_sel;
        end
    end

    // output stage
    logic       ovalid_reg;
    logic [7:0] odata_reg;
    logic       olast_reg;
    logic [1:0] ouser_reg;
    logic       out_load;

    assign out_load = cmd.out_sign || cmd.out_digit || cmd.out_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_sign)
        begin
            odata_reg <= rconv_pkg::NEG_MARK;
            olast_reg <= 1'b0;
            ouser_reg <= rconv_pkg::ST_OK;
        end
        else if (cmd.out_digit)
        begin
            odata_reg <= rd_data_reg;
            olast_reg <= (sp_reg == '0);
            ouser_reg <= rconv_pkg::ST_OK;
        end
        else if (cmd.out_err)
        begin
            odata_reg <= 8'd0;
            olast_reg <= 1'b1;
            ouser_reg <= st_sel_q_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

    assign stat.sel_err     = (st_sel != rconv_pkg::ST_OK);
    assign stat.bit_last    = (bit_reg == '0);
    assign stat.quot_zero   = (q_reg == '0);
    assign stat.stack_full  = (sp_reg == CW'(STACK_DEPTH));
    assign stat.neg_emit    = nege_reg;
    assign stat.stack_empty = (sp_reg == '0);
    assign stat.out_free    = !ovalid_reg || m_tready;

endmodule

`default_nettype wire

>>> hw/rtl/radix_converter_top.sv
// Radix converter: signed integer digits in, digits in another base out.
// Steps: each non-last digit is taken in IDLE; the last digit brings a load step, then
//   per output digit VALUE_BITS-1 quotient bits and a check step, a sign step
//   taken with or without a sign, then a pop and an emit step per emitted digit; an
//   error beat goes out after the load. Output stalls hold sign, emit and error steps.
// Throughput: one number at a time; rst_n (async) clears control, state and bases (10 / 2).
`default_nettype none

module radix_converter_top
#(
    parameter int VALUE_BITS  = rconv_pkg::VALUE_BITS_DEF,   // 8..64
    parameter int STACK_DEPTH = rconv_pkg::STACK_DEPTH_DEF   // 8..64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write port
    input  wire logic                cfg_we,
    input  wire rconv_pkg::cfg_reg_t cfg_addr,   // 0 source_base, 1 target_base
    input  wire logic [7:0]          cfg_data,
    // input digits
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,    // [7:0] digit_in
    input  wire logic                s_tlast,    // last_in
    // output digits
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,    // [7:0] digit_out
    output logic                     m_tlast,    // last_out
    output logic [1:0]               m_tuser     // [1:0] status
);

    rconv_pkg::ctrl_cmd_t cmd;
    rconv_pkg::dp_stat_t  stat;

    // sequencer: accept, load, divide, unstack; input is blocked from the
    // last digit until the final beat sits in the output register
    rconv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // accumulator, divider, digit stack and output beat register
    rconv_dp
    #(
        .VALUE_BITS  (VALUE_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .digit_in (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> sim/tb_radix_converter_top.sv
// Self-checking testbench for radix_converter_top: digit streams in, converted digits out.
// Depends on rconv_pkg and radix_converter_top; a built-in predictor checks every output beat.
`timescale 1ns / 1ps

module tb_radix_converter_top;

    localparam logic [31:0] MAG_LIMIT   = 32'h7FFF_FFFF;
    localparam int          STACK_SLOTS = rconv_pkg::STACK_DEPTH_DEF;
    localparam int          TOTAL_ITEMS = 130;
    localparam int          QUIET_FROM  = 100;    // no idling from here on
    localparam int          HOLDOFF     = 100;    // settle cycles before a register write
    localparam int          STALL_LIMIT = 20000;  // cycles with no beat before giving up

    typedef struct {
        logic [7:0] digit;
        logic       last;
    } in_beat_t;

    typedef struct {
        logic [7:0]         digit;
        logic               last;
        rconv_pkg::status_t status;
    } out_beat_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    rconv_pkg::cfg_reg_t cfg_addr = rconv_pkg::REG_SOURCE_BASE;
    logic [7:0]          cfg_data = 8'd0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'd0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tlast;
    logic [1:0]          m_tuser;

    radix_converter_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: register copies and per-number state
    logic [7:0]         m_src   = rconv_pkg::SOURCE_BASE_RST;
    logic [7:0]         m_tgt   = rconv_pkg::TARGET_BASE_RST;
    logic [31:0]        m_acc   = 32'd0;
    logic               m_neg   = 1'b0;
    logic [31:0]        m_count = 32'd0;
    rconv_pkg::status_t m_err   = rconv_pkg::ST_OK;

    in_beat_t  pending_digits[$];
    out_beat_t digits_due[$];
    in_beat_t  next_beat;
    out_beat_t want;

    int  n_pushed     = 0;
    int  n_taken      = 0;
    int  mismatches   = 0;
    int  in_gap       = 0;
    int  out_stall    = 0;
    int  quiet_cycles = 0;
    bit  in_taken     = 1'b0;
    bit  no_idle      = 1'b0;

    // Accumulate one source digit; on the last one, queue the converted digits or the error beat.
    task automatic convert_digit(input logic [7:0] d, input logic last);
        logic [31:0]        value;
        logic               neg;
        rconv_pkg::status_t st;
        logic [7:0]         tb;
        logic [7:0]         digs [STACK_SLOTS];
        int                 n;
        if (m_count <= MAG_LIMIT)
            m_count++;
        if (m_src != 8'd1)
        begin
            if (d == rconv_pkg::NEG_MARK)
            begin
                m_acc = 32'd0;
                m_neg = 1'b1;
                m_err = rconv_pkg::ST_OK;
            end
            else if (m_err == rconv_pkg::ST_OK)
            begin
                if (d >= m_src)
                    m_err = rconv_pkg::ST_BAD_DIGIT;
                else if (m_acc > (MAG_LIMIT - d) / m_src)
                    m_err = rconv_pkg::ST_OVERFLOW;
                else
                    m_acc = m_acc * m_src + d;
            end
        end
        if (!last)
            return;
        if (m_src == 8'd1)
        begin
            value = m_count;
            neg   = 1'b0;
            st    = (m_count > MAG_LIMIT) ? rconv_pkg::ST_OVERFLOW : rconv_pkg::ST_OK;
        end
        else
        begin
            value = m_acc;
            neg   = m_neg;
            st    = m_err;
        end
        m_acc   = 32'd0;
        m_neg   = 1'b0;
        m_count = 32'd0;
        m_err   = rconv_pkg::ST_OK;
        if (st != rconv_pkg::ST_OK)
        begin
            digits_due.push_back('{8'd0, 1'b1, st});
            return;
        end
        tb = (m_tgt < rconv_pkg::MIN_TARGET_BASE) ? rconv_pkg::MIN_TARGET_BASE : m_tgt;
        n  = 0;
        do
        begin
            digs[n] = 8'(value % tb);
            value   = value / tb;
            n++;
        end
        while (value != 0 && n < STACK_SLOTS);
        // negative zero comes out without the sign mark
        if (neg && !(n == 1 && digs[0] == 8'd0))
            digits_due.push_back('{rconv_pkg::NEG_MARK, 1'b0, rconv_pkg::ST_OK});
        while (n > 0)
        begin
            n--;
            digits_due.push_back('{digs[n], n == 0, rconv_pkg::ST_OK});
        end
    endtask

    task automatic push_item(input logic [7:0] d, input logic l);
        pending_digits.push_back('{d, l});
        n_pushed++;
    endtask

    // One random number: mostly well-formed in the current base, some raw bytes.
    task automatic queue_random_number();
        int         len;
        logic [7:0] d;
        len = $urandom_range(1, 4);
        if ($urandom_range(0, 5) == 0)
        begin
            for (int k = 0; k < len; k++)
            begin
                d = 8'($urandom_range(0, 255));
                push_item(d, k == len - 1);
            end
        end
        else
        begin
            if (m_src != 8'd1 && $urandom_range(0, 3) == 0)
                push_item(rconv_pkg::NEG_MARK, 1'b0);
            for (int k = 0; k < len; k++)
            begin
                if (m_src >= 8'd2)
                    d = 8'($urandom_range(0, int'(m_src) - 1));
                else
                    d = 8'($urandom_range(0, 255));
                push_item(d, k == len - 1);
            end
        end
    endtask

    task automatic wait_drained(input int settle);
        while (n_taken != n_pushed || digits_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input rconv_pkg::cfg_reg_t addr, input logic [7:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        if (addr == rconv_pkg::REG_SOURCE_BASE)
            m_src = val;
        else
            m_tgt = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // input side: one beat held until taken, random gaps between beats
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_digits.size() != 0)
            begin
                next_beat = pending_digits.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.digit;
                s_tlast  <= next_beat.last;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    in_gap = $urandom_range(1, 10);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: random backpressure bursts
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0)
                out_stall = $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_taken = 1'b1;
            n_taken++;
            convert_digit(s_tdata, s_tlast);
        end
        if (m_tvalid && m_tready)
        begin
            if (digits_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %0d last %0d status %0d",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                want = digits_due.pop_front();
                if (m_tdata !== want.digit)
                begin
                    $display("%0t: digit_out expected %0d actual %0d",
                             $time, want.digit, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_out expected %0d actual %0d",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset bases 10 -> 2: zero, negative zero, digits before the sign mark
        push_item(8'd0, 1'b1);
        push_item(rconv_pkg::NEG_MARK, 1'b0); push_item(8'd0, 1'b1);
        push_item(8'd1, 1'b0); push_item(rconv_pkg::NEG_MARK, 1'b0);
        push_item(8'd7, 1'b0); push_item(8'd3, 1'b1);
        // a digit, then a last digit not below the base
        push_item(8'd5, 1'b0); push_item(8'd12, 1'b1);
        // leave a number open across a base change
        push_item(8'd4, 1'b0);
        wait_drained(HOLDOFF);

        // unary count, sign mark just counted
        write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd1);
        write_reg(rconv_pkg::REG_TARGET_BASE, 8'd254);
        push_item(rconv_pkg::NEG_MARK, 1'b0); push_item(8'd7, 1'b1);
        push_item(8'd3, 1'b0);
        wait_drained(HOLDOFF);

        // back to positional mid-number; largest magnitude, target base zero
        write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd254);
        write_reg(rconv_pkg::REG_TARGET_BASE, 8'd0);
        push_item(8'd131, 1'b0); push_item(8'd12, 1'b0);
        push_item(8'd16, 1'b0); push_item(8'd7, 1'b1);
        wait_drained(HOLDOFF);

        // target base one; most negative value, then one past the limit
        write_reg(rconv_pkg::REG_TARGET_BASE, 8'd1);
        push_item(rconv_pkg::NEG_MARK, 1'b0);
        push_item(8'd131, 1'b0); push_item(8'd12, 1'b0);
        push_item(8'd16, 1'b0); push_item(8'd7, 1'b1);
        push_item(8'd131, 1'b0); push_item(8'd12, 1'b0);
        push_item(8'd16, 1'b0); push_item(8'd8, 1'b1);

        while (n_pushed < TOTAL_ITEMS)
        begin
            wait_drained(HOLDOFF);
            case ($urandom_range(0, 5))
                0:       write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd1);
                1:       write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd2);
                2:       write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd10);
                3:       write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd254);
                4:       write_reg(rconv_pkg::REG_SOURCE_BASE, 8'd0);
                default: write_reg(rconv_pkg::REG_SOURCE_BASE, 8'($urandom_range(3, 253)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(rconv_pkg::REG_TARGET_BASE, 8'd0);
                1:       write_reg(rconv_pkg::REG_TARGET_BASE, 8'd1);
                2:       write_reg(rconv_pkg::REG_TARGET_BASE, 8'd2);
                3:       write_reg(rconv_pkg::REG_TARGET_BASE, 8'd16);
                4:       write_reg(rconv_pkg::REG_TARGET_BASE, 8'd254);
                default: write_reg(rconv_pkg::REG_TARGET_BASE, 8'($urandom_range(3, 253)));
            endcase
            if (n_pushed >= QUIET_FROM)
                no_idle = 1'b1;
            repeat ($urandom_range(3, 6)) queue_random_number();
        end

        wait_drained(2 * HOLDOFF);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rconv_pkg.sv
hw/rtl/rconv_ctrl.sv
hw/rtl/rconv_dp.sv
hw/rtl/radix_converter_top.sv
sim/tb_radix_converter_top.sv
